// ===== hdl/fbpa_pkg.sv =====
// Shared types and constants of the fixed block pool allocator.
// Used by every module of the block but fbpa_ram; depends on nothing.
package fbpa_pkg;

    localparam int DATA_W  = 32;  // configuration bus width
    localparam int ADDR_W  = 4;   // byte address of three 32-bit registers
    localparam int COUNT_W = 9;   // width of the block counts on the ports

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_BASE_ADDRESS = 2'd0;
    localparam logic [1:0] REG_BLOCK_BYTES  = 2'd1;
    localparam logic [1:0] REG_BLOCK_TOTAL  = 2'd2;

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_INIT  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_BAD   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ALLOC,
        S_FILL
    } t_state;

    typedef struct packed {
        t_action     action;
        logic [31:0] block_address;
    } t_request;

    typedef struct packed {
        t_status            status;
        logic [31:0]        granted_address;
        logic [COUNT_W-1:0] free_blocks;
        logic [COUNT_W-1:0] used_blocks;
    } t_result;

    typedef struct packed {
        logic [31:0]        base_address;
        logic [15:0]        block_bytes;
        logic [COUNT_W-1:0] block_total;
    } t_cfg;

endpackage

// ===== hdl/fbpa_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Standalone; no package needed.
module fbpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/fbpa_regs.sv =====
// APB configuration registers of the allocator: base address, block size
// and block count. Depends on fbpa_pkg.
module fbpa_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic [fbpa_pkg::ADDR_W-1:0] i_paddr,
    input  logic [fbpa_pkg::DATA_W-1:0] i_pwdata,
    output logic [fbpa_pkg::DATA_W-1:0] o_prdata,
    output logic                       o_pready,
    output fbpa_pkg::t_cfg             o_cfg
);
    import fbpa_pkg::*;

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign reg_idx = i_paddr[3:2];
    assign wr_en   = i_psel && i_penable && i_pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_BASE_ADDRESS: n_cfg.base_address = i_pwdata;
                REG_BLOCK_BYTES:  n_cfg.block_bytes  = i_pwdata[15:0];
                REG_BLOCK_TOTAL:  n_cfg.block_total  = i_pwdata[COUNT_W-1:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_address <= '0;
            r_cfg.block_bytes  <= 16'd8;
            r_cfg.block_total  <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_BASE_ADDRESS: o_prdata = r_cfg.base_address;
            REG_BLOCK_BYTES:  o_prdata = {16'd0, r_cfg.block_bytes};
            REG_BLOCK_TOTAL:  o_prdata = {{(DATA_W-COUNT_W){1'b0}}, r_cfg.block_total};
            default:          o_prdata = '0;
        endcase
    end

    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

endmodule

// ===== hdl/fbpa_ctrl.sv =====
// Request sequencer of the allocator: ring pointers, counts, the fill sweep
// and the result register. Drives the ring RAM; depends on fbpa_pkg.
module fbpa_ctrl #(
    parameter int MAX_BLOCKS     = 256,
    parameter int MIN_BLOCK_SIZE = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  fbpa_pkg::t_request            i_request,
    input  fbpa_pkg::t_cfg                i_cfg,
    output logic                          o_busy,
    output logic                          o_done,
    output fbpa_pkg::t_result             o_result,
    output logic                          o_ram_we,
    output logic [$clog2(MAX_BLOCKS)-1:0] o_ram_waddr,
    output logic [31:0]                   o_ram_wdata,
    output logic                          o_ram_re,
    output logic [$clog2(MAX_BLOCKS)-1:0] o_ram_raddr,
    input  logic [31:0]                   i_ram_rdata
);
    import fbpa_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_head, n_head;
    logic [IDX_W-1:0]   r_tail, n_tail;
    logic [CNT_W-1:0]   r_free, n_free;
    logic [CNT_W-1:0]   r_pool, n_pool;
    logic               r_ready, n_ready;
    logic [CNT_W-1:0]   r_fill_idx, n_fill_idx;
    logic [31:0]        r_fill_addr, n_fill_addr;
    logic               r_done, n_done;
    t_result            r_result, n_result;

    logic [CMP_W-1:0]   total_ext;
    logic               bad_cfg;
    logic [CNT_W-1:0]   used;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(MAX_BLOCKS - 1)) ? '0 : IDX_W'(idx + 1'b1);
    endfunction

    assign total_ext = CMP_W'(i_cfg.block_total);
    assign bad_cfg   = (i_cfg.block_bytes < 16'(MIN_BLOCK_SIZE))
                    || (total_ext > CMP_W'(MAX_BLOCKS));

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_free      = r_free;
        n_pool      = r_pool;
        n_ready     = r_ready;
        n_fill_idx  = r_fill_idx;
        n_fill_addr = r_fill_addr;
        n_done      = 1'b0;
        n_result    = r_result;
        n_result.granted_address = '0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_tail;
        o_ram_wdata = i_request.block_address;
        o_ram_re    = 1'b0;
        o_ram_raddr = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_request.action)
                        ACT_INIT: begin
                            if (bad_cfg) begin
                                n_done          = 1'b1;
                                n_result.status = STAT_BAD;
                            end else if (total_ext == '0) begin
                                n_head          = '0;
                                n_tail          = '0;
                                n_free          = '0;
                                n_pool          = '0;
                                n_ready         = 1'b1;
                                n_done          = 1'b1;
                                n_result.status = STAT_OK;
                            end else begin
                                n_state     = S_FILL;
                                n_fill_idx  = '0;
                                n_fill_addr = i_cfg.base_address;
                            end
                        end
                        ACT_ALLOC: begin
                            if (!r_ready) begin
                                n_done          = 1'b1;
                                n_result.status = STAT_BAD;
                            end else if (r_free == '0) begin
                                n_done          = 1'b1;
                                n_result.status = STAT_EMPTY;
                            end else begin
                                o_ram_re = 1'b1;
                                n_state  = S_ALLOC;
                            end
                        end
                        ACT_FREE: begin
                            n_done = 1'b1;
                            if (!r_ready) begin
                                n_result.status = STAT_BAD;
                            end else if (r_free == CNT_W'(MAX_BLOCKS)) begin
                                n_result.status = STAT_FULL;
                            end else begin
                                o_ram_we        = 1'b1;
                                n_tail          = ring_next(r_tail);
                                n_free          = CNT_W'(r_free + 1'b1);
                                n_result.status = STAT_OK;
                            end
                        end
                        ACT_QUERY: begin
                            n_done          = 1'b1;
                            n_result.status = r_ready ? STAT_OK : STAT_BAD;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_ALLOC: begin
                n_state                  = S_IDLE;
                n_done                   = 1'b1;
                n_result.status          = STAT_OK;
                n_result.granted_address = i_ram_rdata;
                n_head                   = ring_next(r_head);
                n_free                   = CNT_W'(r_free - 1'b1);
            end
            S_FILL: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = IDX_W'(r_fill_idx);
                o_ram_wdata = r_fill_addr;
                n_fill_idx  = CNT_W'(r_fill_idx + 1'b1);
                n_fill_addr = r_fill_addr + {16'd0, i_cfg.block_bytes};
                if (r_fill_idx == CNT_W'(total_ext - CMP_W'(1))) begin
                    // Last block written: the ring now holds the whole pool.
                    n_state         = S_IDLE;
                    n_head          = '0;
                    n_tail          = (total_ext >= CMP_W'(MAX_BLOCKS)) ? '0
                                                                      : IDX_W'(total_ext);
                    n_free          = CNT_W'(total_ext);
                    n_pool          = CNT_W'(total_ext);
                    n_ready         = 1'b1;
                    n_done          = 1'b1;
                    n_result.status = STAT_OK;
                end
            end
            default: n_state = S_IDLE;
        endcase

        used                 = (n_pool > n_free) ? CNT_W'(n_pool - n_free) : '0;
        n_result.free_blocks = COUNT_W'(n_free);
        n_result.used_blocks = COUNT_W'(used);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_free  <= '0;
            r_pool  <= '0;
            r_ready <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_free  <= n_free;
            r_pool  <= n_pool;
            r_ready <= n_ready;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fill_idx  <= n_fill_idx;
        r_fill_addr <= n_fill_addr;
        r_result    <= n_result;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ===== hdl/fixed_block_pool_allocator.sv =====
// Top level of the fixed block pool allocator: APB registers, request
// sequencer and free-address ring RAM. Depends on fbpa_pkg and all hdl modules.
//
// The allocator keeps the addresses of free fixed-size blocks in a FIFO ring
// held in a synchronous RAM of MAX_BLOCKS 32-bit entries. A request is taken
// when start is high and busy is low; its result appears on o_result for
// exactly one cycle, flagged by o_done, and must be captured then because the
// receiver cannot stall the block. Free and query requests, and requests that
// fail (pool not ready, pool empty, ring full, bad configuration) never raise
// busy and can be issued back to back. An allocate that succeeds goes through
// S_ALLOC, because the ring entry comes out of the registered RAM read port in
// the cycle after its address is applied. A good initialise request sweeps the
// ring, writing one block address per cycle through the single RAM write port
// (a zero block_total needs no sweep). Each result is flagged on o_done in the
// cycle after the sequencer finishes the request, and busy is already low in
// that cycle so the next request may enter. The registers are
// sampled while an initialise request runs and must only be written while no
// request is outstanding.
module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS     = 256,
    parameter int MIN_BLOCK_SIZE = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  fbpa_pkg::t_request          i_request,
    output logic                        busy,
    output logic                        o_done,
    output fbpa_pkg::t_result           o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fbpa_pkg::ADDR_W-1:0] paddr,
    input  logic [fbpa_pkg::DATA_W-1:0] pwdata,
    output logic [fbpa_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import fbpa_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);

    t_cfg             cfg;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [31:0]      ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [31:0]      ram_rdata;

    // Configuration registers; reset leaves an 8-byte block size and an
    // empty region at address zero.
    fbpa_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (cfg)
    );

    // The sequencer owns the ring pointers and counts. Only one request is
    // in flight at a time, so a ring read never meets a write to the same
    // entry in the same cycle and no forwarding path is needed.
    fbpa_ctrl #(
        .MAX_BLOCKS     (MAX_BLOCKS),
        .MIN_BLOCK_SIZE (MIN_BLOCK_SIZE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_request   (i_request),
        .i_cfg       (cfg),
        .o_busy      (busy),
        .o_done      (o_done),
        .o_result    (o_result),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    // Free-address ring. Entries are never read before they are written,
    // so the RAM needs no clearing after reset.
    fbpa_ram #(
        .WIDTH (32),
        .DEPTH (MAX_BLOCKS)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // A result is only flagged while the sequencer is idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while the sequencer is busy");

    // A request other than initialise either answers in the next cycle or
    // is still being worked on then.
    a_req_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_request.action != ACT_INIT)) |=> (o_done || busy))
        else $error("accepted request produced neither a result nor work");

    // Only a successful allocation hands out an address.
    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status != STAT_OK)) |-> (o_result.granted_address == '0))
        else $error("address granted with a failing status");

    // An empty-pool answer must agree with the reported free count.
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status == STAT_EMPTY)) |-> (o_result.free_blocks == '0))
        else $error("pool reported empty with free blocks left");

endmodule
